/* src/rms_pkg.sv */
// rms_pkg: shared types, constants and the microcode program of the running moment block
// used by rms_ctrl, rms_dp and running_moment_statistics; depends on nothing else
`default_nettype none

package rms_pkg;

    // fixed-point and range constants
    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_COUNT   = 65535;
    localparam int CNT_BITS    = 16;

    // width of the working registers, wide enough for every intermediate term
    localparam int DW       = 136;
    localparam int DCNT_W   = $clog2(DW + 1);
    localparam int SQ_STEPS = 56;

    // output field widths
    localparam int MEAN_W = 28;
    localparam int VAR_W  = 38;
    localparam int STD_W  = 28;
    localparam int SKEW_W = 26;
    localparam int KURT_W = 34;

    // register file addresses
    localparam int RA_W = 5;
    localparam logic [RA_W-1:0] R_N    = 5'd0;
    localparam logic [RA_W-1:0] R_NM1  = 5'd1;
    localparam logic [RA_W-1:0] R_S1   = 5'd2;
    localparam logic [RA_W-1:0] R_S2   = 5'd3;
    localparam logic [RA_W-1:0] R_S3   = 5'd4;
    localparam logic [RA_W-1:0] R_S4   = 5'd5;
    localparam logic [RA_W-1:0] R_K1   = 5'd6;
    localparam logic [RA_W-1:0] R_K2   = 5'd7;
    localparam logic [RA_W-1:0] R_K3   = 5'd8;
    localparam logic [RA_W-1:0] R_K4   = 5'd9;
    localparam logic [RA_W-1:0] R_K6   = 5'd10;
    localparam logic [RA_W-1:0] R_NN   = 5'd11;
    localparam logic [RA_W-1:0] R_NNN  = 5'd12;
    localparam logic [RA_W-1:0] R_C2   = 5'd13;
    localparam logic [RA_W-1:0] R_C3   = 5'd14;
    localparam logic [RA_W-1:0] R_C4   = 5'd15;
    localparam logic [RA_W-1:0] R_T0   = 5'd16;
    localparam logic [RA_W-1:0] R_T1   = 5'd17;
    localparam logic [RA_W-1:0] R_T2   = 5'd18;
    localparam logic [RA_W-1:0] R_T3   = 5'd19;
    localparam logic [RA_W-1:0] R_T4   = 5'd20;
    localparam logic [RA_W-1:0] R_T5   = 5'd21;
    localparam logic [RA_W-1:0] R_MEAN = 5'd22;
    localparam logic [RA_W-1:0] R_VAR  = 5'd23;
    localparam logic [RA_W-1:0] R_PSTD = 5'd24;
    localparam logic [RA_W-1:0] R_SSTD = 5'd25;
    localparam logic [RA_W-1:0] R_G1   = 5'd26;
    localparam logic [RA_W-1:0] R_G2   = 5'd27;
    localparam logic [RA_W-1:0] R_B1   = 5'd28;
    localparam logic [RA_W-1:0] R_BG1  = 5'd29;
    localparam logic [RA_W-1:0] R_BG2  = 5'd30;
    localparam logic [RA_W-1:0] R_B2   = 5'd31;

    // immediate codes for loading the accumulators
    localparam int IMM_W = 6;
    localparam logic [IMM_W-1:0] LD_N  = 6'd0;
    localparam logic [IMM_W-1:0] LD_S1 = 6'd1;
    localparam logic [IMM_W-1:0] LD_S2 = 6'd2;
    localparam logic [IMM_W-1:0] LD_S3 = 6'd3;
    localparam logic [IMM_W-1:0] LD_S4 = 6'd4;
    localparam logic [IMM_W-1:0] SH_F  = IMM_W'(FRAC_BITS);
    localparam logic [IMM_W-1:0] SH_2F = IMM_W'(2 * FRAC_BITS);

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SQRT, OP_SHL, OP_LDI, OP_LDS, OP_END
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [RA_W-1:0]  dst;
        logic [RA_W-1:0]  a;
        logic [RA_W-1:0]  b;
        logic [IMM_W-1:0] imm;
    } t_instr;

    localparam int PC_W = 7;

    // controller to datapath commands
    typedef struct packed {
        logic   accept;
        logic   clear;
        logic   upd_sq;
        logic   upd_pow;
        logic   upd_sum;
        logic   rd;
        logic   start;
        logic   wr;
        logic   publish;
        logic   pub_clr;
        t_instr ins;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_sts;

    function automatic t_instr mk(input t_op op, input logic [RA_W-1:0] dst,
                                  input logic [RA_W-1:0] a, input logic [RA_W-1:0] b,
                                  input logic [IMM_W-1:0] imm);
        t_instr r;
        r.op  = op;
        r.dst = dst;
        r.a   = a;
        r.b   = b;
        r.imm = imm;
        return r;
    endfunction

    // microcode: central sums, then each statistic
    function automatic t_instr prog(input logic [PC_W-1:0] pc);
        t_instr r;
        case (pc)
            7'd0:  r = mk(OP_LDS, R_N,   R_N,   R_N,   LD_N);
            7'd1:  r = mk(OP_LDS, R_S1,  R_N,   R_N,   LD_S1);
            7'd2:  r = mk(OP_LDS, R_S2,  R_N,   R_N,   LD_S2);
            7'd3:  r = mk(OP_LDS, R_S3,  R_N,   R_N,   LD_S3);
            7'd4:  r = mk(OP_LDS, R_S4,  R_N,   R_N,   LD_S4);
            7'd5:  r = mk(OP_LDI, R_K1,  R_N,   R_N,   6'd1);
            7'd6:  r = mk(OP_SUB, R_NM1, R_N,   R_K1,  6'd0);
            7'd7:  r = mk(OP_MUL, R_T0,  R_S1,  R_S1,  6'd0);
            7'd8:  r = mk(OP_MUL, R_T1,  R_N,   R_S2,  6'd0);
            7'd9:  r = mk(OP_SUB, R_C2,  R_T1,  R_T0,  6'd0);
            7'd10: r = mk(OP_MUL, R_NN,  R_N,   R_N,   6'd0);
            7'd11: r = mk(OP_MUL, R_T1,  R_NN,  R_S3,  6'd0);
            7'd12: r = mk(OP_MUL, R_T2,  R_S1,  R_S2,  6'd0);
            7'd13: r = mk(OP_MUL, R_T3,  R_N,   R_T2,  6'd0);
            7'd14: r = mk(OP_LDI, R_K3,  R_N,   R_N,   6'd3);
            7'd15: r = mk(OP_MUL, R_T3,  R_T3,  R_K3,  6'd0);
            7'd16: r = mk(OP_SUB, R_T1,  R_T1,  R_T3,  6'd0);
            7'd17: r = mk(OP_MUL, R_T2,  R_S1,  R_T0,  6'd0);
            7'd18: r = mk(OP_LDI, R_K2,  R_N,   R_N,   6'd2);
            7'd19: r = mk(OP_MUL, R_T2,  R_T2,  R_K2,  6'd0);
            7'd20: r = mk(OP_ADD, R_C3,  R_T1,  R_T2,  6'd0);
            7'd21: r = mk(OP_MUL, R_NNN, R_NN,  R_N,   6'd0);
            7'd22: r = mk(OP_MUL, R_T1,  R_NNN, R_S4,  6'd0);
            7'd23: r = mk(OP_MUL, R_T2,  R_S1,  R_S3,  6'd0);
            7'd24: r = mk(OP_MUL, R_T2,  R_NN,  R_T2,  6'd0);
            7'd25: r = mk(OP_LDI, R_K4,  R_N,   R_N,   6'd4);
            7'd26: r = mk(OP_MUL, R_T2,  R_T2,  R_K4,  6'd0);
            7'd27: r = mk(OP_SUB, R_T1,  R_T1,  R_T2,  6'd0);
            7'd28: r = mk(OP_MUL, R_T2,  R_T0,  R_S2,  6'd0);
            7'd29: r = mk(OP_MUL, R_T2,  R_N,   R_T2,  6'd0);
            7'd30: r = mk(OP_LDI, R_K6,  R_N,   R_N,   6'd6);
            7'd31: r = mk(OP_MUL, R_T2,  R_T2,  R_K6,  6'd0);
            7'd32: r = mk(OP_ADD, R_T1,  R_T1,  R_T2,  6'd0);
            7'd33: r = mk(OP_MUL, R_T2,  R_T0,  R_T0,  6'd0);
            7'd34: r = mk(OP_MUL, R_T2,  R_T2,  R_K3,  6'd0);
            7'd35: r = mk(OP_SUB, R_C4,  R_T1,  R_T2,  6'd0);
            // mean and variance
            7'd36: r = mk(OP_SHL, R_T1,  R_S1,  R_N,   SH_F);
            7'd37: r = mk(OP_DIV, R_MEAN, R_T1, R_N,   6'd0);
            7'd38: r = mk(OP_SHL, R_T1,  R_C2,  R_N,   SH_F);
            7'd39: r = mk(OP_DIV, R_VAR, R_T1,  R_NN,  6'd0);
            // standard deviations
            7'd40: r = mk(OP_SHL, R_T2,  R_C2,  R_N,   SH_2F);
            7'd41: r = mk(OP_DIV, R_T1,  R_T2,  R_NN,  6'd0);
            7'd42: r = mk(OP_SQRT, R_PSTD, R_T1, R_N,  6'd0);
            7'd43: r = mk(OP_MUL, R_T3,  R_N,   R_NM1, 6'd0);
            7'd44: r = mk(OP_DIV, R_T1,  R_T2,  R_T3,  6'd0);
            7'd45: r = mk(OP_SQRT, R_SSTD, R_T1, R_N,  6'd0);
            // g1; a zero divisor gives zero
            7'd46: r = mk(OP_SQRT, R_T1, R_T2,  R_N,   6'd0);
            7'd47: r = mk(OP_MUL, R_T1,  R_C2,  R_T1,  6'd0);
            7'd48: r = mk(OP_SHL, R_T3,  R_C3,  R_N,   SH_2F);
            7'd49: r = mk(OP_DIV, R_G1,  R_T3,  R_T1,  6'd0);
            // g2
            7'd50: r = mk(OP_MUL, R_T1,  R_C2,  R_C2,  6'd0);
            7'd51: r = mk(OP_SHL, R_T3,  R_C4,  R_N,   SH_F);
            7'd52: r = mk(OP_DIV, R_T3,  R_T3,  R_T1,  6'd0);
            7'd53: r = mk(OP_SHL, R_T1,  R_K3,  R_N,   SH_F);
            7'd54: r = mk(OP_SUB, R_G2,  R_T3,  R_T1,  6'd0);
            // b1
            7'd55: r = mk(OP_MUL, R_T2,  R_NM1, R_NM1, 6'd0);
            7'd56: r = mk(OP_MUL, R_T2,  R_T2,  R_NM1, 6'd0);
            7'd57: r = mk(OP_SHL, R_T2,  R_T2,  R_N,   SH_2F);
            7'd58: r = mk(OP_DIV, R_T2,  R_T2,  R_NNN, 6'd0);
            7'd59: r = mk(OP_SQRT, R_T2, R_T2,  R_N,   6'd0);
            7'd60: r = mk(OP_MUL, R_T2,  R_G1,  R_T2,  6'd0);
            7'd61: r = mk(OP_SHL, R_T3,  R_K1,  R_N,   SH_F);
            7'd62: r = mk(OP_DIV, R_B1,  R_T2,  R_T3,  6'd0);
            // G1
            7'd63: r = mk(OP_MUL, R_T2,  R_N,   R_NM1, 6'd0);
            7'd64: r = mk(OP_SHL, R_T2,  R_T2,  R_N,   SH_2F);
            7'd65: r = mk(OP_SQRT, R_T2, R_T2,  R_N,   6'd0);
            7'd66: r = mk(OP_MUL, R_T2,  R_G1,  R_T2,  6'd0);
            7'd67: r = mk(OP_SUB, R_T4,  R_N,   R_K2,  6'd0);
            7'd68: r = mk(OP_SHL, R_T0,  R_T4,  R_N,   SH_F);
            7'd69: r = mk(OP_DIV, R_BG1, R_T2,  R_T0,  6'd0);
            // G2
            7'd70: r = mk(OP_ADD, R_T5,  R_N,   R_K1,  6'd0);
            7'd71: r = mk(OP_MUL, R_T5,  R_T5,  R_G2,  6'd0);
            7'd72: r = mk(OP_SHL, R_T0,  R_K6,  R_N,   SH_F);
            7'd73: r = mk(OP_ADD, R_T5,  R_T5,  R_T0,  6'd0);
            7'd74: r = mk(OP_MUL, R_T5,  R_T5,  R_NM1, 6'd0);
            7'd75: r = mk(OP_SUB, R_T0,  R_N,   R_K3,  6'd0);
            7'd76: r = mk(OP_MUL, R_T0,  R_T4,  R_T0,  6'd0);
            7'd77: r = mk(OP_DIV, R_BG2, R_T5,  R_T0,  6'd0);
            // b2, three in fixed point still sits in T1
            7'd78: r = mk(OP_ADD, R_T5,  R_G2,  R_T1,  6'd0);
            7'd79: r = mk(OP_MUL, R_T0,  R_NM1, R_NM1, 6'd0);
            7'd80: r = mk(OP_MUL, R_T5,  R_T5,  R_T0,  6'd0);
            7'd81: r = mk(OP_DIV, R_T5,  R_T5,  R_NN,  6'd0);
            7'd82: r = mk(OP_SUB, R_B2,  R_T5,  R_T1,  6'd0);
            default: r = mk(OP_END, R_N, R_N,   R_N,   6'd0);
        endcase
        return r;
    endfunction

    // clamp to a signed range of the given width
    function automatic logic [DW-1:0] sat_s(input logic [DW-1:0] v, input int bits);
        logic [DW-1:0] hi;
        logic [DW-1:0] lo;
        logic [DW-1:0] r;
        hi = (DW'(1) << (bits - 1)) - DW'(1);
        lo = ~hi;
        r  = v;
        if ($signed(v) > $signed(hi)) r = hi;
        if ($signed(v) < $signed(lo)) r = lo;
        return r;
    endfunction

    // clamp to an unsigned range of the given width
    function automatic logic [DW-1:0] sat_u(input logic [DW-1:0] v, input int bits);
        logic [DW-1:0] mx;
        logic [DW-1:0] r;
        mx = (DW'(1) << bits) - DW'(1);
        r  = v;
        if (v[DW-1]) r = '0;
        else if (v > mx) r = mx;
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/running_moment_statistics.sv */
// running_moment_statistics: top level joining the sequencer and the datapath
// depends on rms_pkg, rms_ctrl and rms_dp
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_func, i_sample
//   result    out        o_out_valid / i_out_stall  o_mean_value .. o_maximum
//
// most of a sample's time goes to the eleven 136-bit divisions
// and the multiplies that run one at a time on the shared iterative unit
// a clear request goes straight to publishing, after any wait for the result register
// a new request is taken only once the previous result has entered the output register
// reset (synchronous, active low) clears the count, the power sums and min/max
// a stalled result holds; the block waits before publishing the next one
`default_nettype none

module running_moment_statistics
    import rms_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_func,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [MEAN_W-1:0]           o_mean_value,
    output logic        [VAR_W-1:0]            o_variance,
    output logic        [STD_W-1:0]            o_population_std,
    output logic        [STD_W-1:0]            o_sample_std,
    output logic signed [SKEW_W-1:0]           o_skew_g1,
    output logic signed [SKEW_W-1:0]           o_skew_big_g1,
    output logic signed [SKEW_W-1:0]           o_skew_b1,
    output logic signed [KURT_W-1:0]           o_kurt_g2,
    output logic signed [KURT_W-1:0]           o_kurt_big_g2,
    output logic signed [KURT_W-1:0]           o_kurt_b2,
    output logic signed [SAMPLE_BITS-1:0]      o_minimum,
    output logic signed [SAMPLE_BITS-1:0]      o_maximum
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer
    rms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // datapath
    rms_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_sample         (i_sample),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_mean_value     (o_mean_value),
        .o_variance       (o_variance),
        .o_population_std (o_population_std),
        .o_sample_std     (o_sample_std),
        .o_skew_g1        (o_skew_g1),
        .o_skew_big_g1    (o_skew_big_g1),
        .o_skew_b1        (o_skew_b1),
        .o_kurt_g2        (o_kurt_g2),
        .o_kurt_big_g2    (o_kurt_big_g2),
        .o_kurt_b2        (o_kurt_b2),
        .o_minimum        (o_minimum),
        .o_maximum        (o_maximum)
    );

endmodule

`default_nettype wire

/* src/rms_ctrl.sv */
// rms_ctrl: sequencer that accepts requests and steps the microcode program
// depends on rms_pkg; drives rms_dp through t_dp_cmd and watches t_dp_sts
`default_nettype none

module rms_ctrl
    import rms_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_func,
    output logic         o_in_stall,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQ, ST_POW, ST_SUM, ST_ISSUE, ST_START, ST_WAIT, ST_DONE
    } t_state;

    t_state          r_state;
    logic [PC_W-1:0] r_pc;
    logic            r_clr;
    t_instr          w_ins;
    logic            w_accept;

    assign w_ins      = prog(r_pc);
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);

    // commands decoded from state
    always_comb begin
        o_cmd         = '0;
        o_cmd.ins     = w_ins;
        o_cmd.pub_clr = r_clr;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = w_accept && !i_func;
                o_cmd.clear  = w_accept && i_func;
            end
            ST_SQ:    o_cmd.upd_sq  = 1'b1;
            ST_POW:   o_cmd.upd_pow = 1'b1;
            ST_SUM:   o_cmd.upd_sum = 1'b1;
            ST_ISSUE: o_cmd.rd      = (w_ins.op != OP_END);
            ST_START: o_cmd.start   = 1'b1;
            ST_WAIT:  o_cmd.wr      = !i_sts.busy;
            ST_DONE:  o_cmd.publish = i_sts.out_free;
            default:  o_cmd.ins     = w_ins;
        endcase
    end

    // state, program counter and clear flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_clr   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_clr   <= i_func;
                        r_pc    <= '0;
                        r_state <= i_func ? ST_DONE : ST_SQ;
                    end
                end
                ST_SQ:  r_state <= ST_POW;
                ST_POW: r_state <= ST_SUM;
                ST_SUM: r_state <= ST_ISSUE;
                ST_ISSUE: begin
                    r_state <= (w_ins.op == OP_END) ? ST_DONE : ST_START;
                end
                ST_START: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (!i_sts.busy) begin
                        r_pc    <= r_pc + PC_W'(1);
                        r_state <= ST_ISSUE;
                    end
                end
                ST_DONE: begin
                    if (i_sts.out_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT && i_sts.busy) |=> o_in_stall)
        else $error("request taken while a step is running");
    a_pc_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE && w_ins.op == OP_END) |=> r_state == ST_DONE)
        else $error("program end not followed by publish");
    a_clear_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |=> (r_state == ST_DONE && r_clr))
        else $error("clear request did not go straight to publish");

endmodule

`default_nettype wire

/* src/rms_dp.sv */
// rms_dp: accumulators, register file, shared iterative multiply/divide/sqrt unit
// and result registers; depends on rms_pkg, commanded by rms_ctrl
`default_nettype none

module rms_dp
    import rms_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_dp_cmd                       i_cmd,
    output t_dp_sts                            o_sts,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic signed [MEAN_W-1:0]           o_mean_value,
    output logic        [VAR_W-1:0]            o_variance,
    output logic        [STD_W-1:0]            o_population_std,
    output logic        [STD_W-1:0]            o_sample_std,
    output logic signed [SKEW_W-1:0]           o_skew_g1,
    output logic signed [SKEW_W-1:0]           o_skew_big_g1,
    output logic signed [SKEW_W-1:0]           o_skew_b1,
    output logic signed [KURT_W-1:0]           o_kurt_g2,
    output logic signed [KURT_W-1:0]           o_kurt_big_g2,
    output logic signed [KURT_W-1:0]           o_kurt_b2,
    output logic signed [SAMPLE_BITS-1:0]      o_minimum,
    output logic signed [SAMPLE_BITS-1:0]      o_maximum
);

    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int CUBE_W = 3 * SAMPLE_BITS;
    localparam int QUAD_W = 4 * SAMPLE_BITS;

    // accumulated state
    logic        [CNT_BITS-1:0]    r_count;
    logic signed [27:0]            r_s1;
    logic signed [39:0]            r_s2;
    logic signed [51:0]            r_s3;
    logic signed [63:0]            r_s4;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;

    // sample powers
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic signed [SQ_W-1:0]        r_sq;
    logic signed [CUBE_W-1:0]      r_cube;
    logic signed [QUAD_W-1:0]      r_quad;

    // register file and operands
    logic [DW-1:0] r_mem [32];
    logic [DW-1:0] r_opa;
    logic [DW-1:0] r_opb;
    logic [DW-1:0] r_res;

    // iterative unit
    t_op             r_op;
    logic            r_busy;
    logic            r_neg;
    logic [DW-1:0]   r_x;
    logic [DW-1:0]   r_y;
    logic [DW-1:0]   r_z;
    logic [DW-1:0]   r_w;
    logic [DCNT_W-1:0] r_cnt;
    logic [DW:0]     w_rem2;
    logic            w_rem_ge;
    logic [DW-1:0]   w_sq_t;
    logic            w_sq_ge;

    // staged results and output registers
    logic [MEAN_W-1:0] r_st_mean;
    logic [VAR_W-1:0]  r_st_var;
    logic [STD_W-1:0]  r_st_pstd;
    logic [STD_W-1:0]  r_st_sstd;
    logic [SKEW_W-1:0] r_st_g1;
    logic [SKEW_W-1:0] r_st_bg1;
    logic [SKEW_W-1:0] r_st_b1;
    logic [KURT_W-1:0] r_st_g2;
    logic [KURT_W-1:0] r_st_bg2;
    logic [KURT_W-1:0] r_st_b2;
    logic              r_ovalid;

    assign o_sts.busy     = r_busy;
    assign o_sts.out_free = !r_ovalid || !i_out_stall;
    assign o_out_valid    = r_ovalid;

    // divider and square root step terms
    assign w_rem2   = {r_x, r_y[DW-1]};
    assign w_rem_ge = (w_rem2 >= {1'b0, r_opb});
    assign w_sq_t   = r_z + r_w;
    assign w_sq_ge  = (r_x >= w_sq_t);

    // accumulators: the sums take the powers once the square and power steps have formed them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_s1    <= '0;
            r_s2    <= '0;
            r_s3    <= '0;
            r_s4    <= '0;
            r_min   <= '0;
            r_max   <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_s1    <= '0;
            r_s2    <= '0;
            r_s3    <= '0;
            r_s4    <= '0;
            r_min   <= '0;
            r_max   <= '0;
        end else if (i_cmd.upd_sum && (r_count < CNT_BITS'(MAX_COUNT))) begin
            r_count <= r_count + CNT_BITS'(1);
            r_s1    <= r_s1 + 28'(r_smp);
            r_s2    <= r_s2 + 40'(r_sq);
            r_s3    <= r_s3 + 52'(r_cube);
            r_s4    <= r_s4 + 64'(r_quad);
            if (r_count == '0) begin
                r_min <= r_smp;
                r_max <= r_smp;
            end else begin
                if (r_smp > r_max) r_max <= r_smp;
                if (r_smp < r_min) r_min <= r_smp;
            end
        end
    end

    // sample and its powers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_smp <= i_sample;
        if (i_cmd.upd_sq) r_sq <= SQ_W'(r_smp) * SQ_W'(r_smp);
        if (i_cmd.upd_pow) begin
            r_cube <= CUBE_W'(r_sq) * CUBE_W'(r_smp);
            r_quad <= QUAD_W'(r_sq) * QUAD_W'(r_sq);
        end
    end

    // register file, two registered reads and one write
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_opa <= r_mem[i_cmd.ins.a];
            r_opb <= r_mem[i_cmd.ins.b];
        end
        if (i_cmd.wr) r_mem[i_cmd.ins.dst] <= r_res;
    end

    // shared execution unit: direct add, sub, shift and loads, shift-add multiply, restoring divide, digit sqrt
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            r_op <= i_cmd.ins.op;
            case (i_cmd.ins.op)
                OP_ADD: r_res <= r_opa + r_opb;
                OP_SUB: r_res <= r_opa - r_opb;
                OP_SHL: r_res <= r_opa << i_cmd.ins.imm;
                OP_LDI: r_res <= DW'(i_cmd.ins.imm);
                OP_LDS: begin
                    case (i_cmd.ins.imm)
                        LD_N:    r_res <= DW'(r_count);
                        LD_S1:   r_res <= DW'(r_s1);
                        LD_S2:   r_res <= DW'(r_s2);
                        LD_S3:   r_res <= DW'(r_s3);
                        LD_S4:   r_res <= DW'(r_s4);
                        default: r_res <= '0;
                    endcase
                end
                OP_MUL: begin
                    r_x    <= '0;
                    r_y    <= r_opa;
                    r_z    <= r_opb[DW-1] ? -r_opb : r_opb;
                    r_neg  <= r_opb[DW-1];
                    r_busy <= 1'b1;
                end
                OP_DIV: begin
                    if (r_opb == '0) begin
                        r_res <= '0;
                    end else begin
                        r_x    <= '0;
                        r_y    <= r_opa[DW-1] ? -r_opa : r_opa;
                        r_z    <= '0;
                        r_neg  <= r_opa[DW-1];
                        r_cnt  <= DCNT_W'(DW);
                        r_busy <= 1'b1;
                    end
                end
                OP_SQRT: begin
                    r_x    <= r_opa;
                    r_z    <= '0;
                    r_w    <= DW'(1) << (2 * (SQ_STEPS - 1));
                    r_busy <= 1'b1;
                end
                default: r_res <= '0;
            endcase
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    if (r_z == '0) begin
                        r_res  <= r_neg ? -r_x : r_x;
                        r_busy <= 1'b0;
                    end else begin
                        if (r_z[0]) r_x <= r_x + r_y;
                        r_y <= r_y << 1;
                        r_z <= r_z >> 1;
                    end
                end
                OP_DIV: begin
                    if (r_cnt == '0) begin
                        r_res  <= r_neg ? -r_z : r_z;
                        r_busy <= 1'b0;
                    end else begin
                        r_x   <= w_rem_ge ? DW'(w_rem2 - {1'b0, r_opb}) : w_rem2[DW-1:0];
                        r_y   <= r_y << 1;
                        r_z   <= {r_z[DW-2:0], w_rem_ge};
                        r_cnt <= r_cnt - DCNT_W'(1);
                    end
                end
                OP_SQRT: begin
                    if (r_w == '0) begin
                        r_res  <= r_z;
                        r_busy <= 1'b0;
                    end else begin
                        if (w_sq_ge) begin
                            r_x <= r_x - w_sq_t;
                            r_z <= (r_z >> 1) + r_w;
                        end else begin
                            r_z <= r_z >> 1;
                        end
                        r_w <= r_w >> 2;
                    end
                end
                default: r_busy <= 1'b0;
            endcase
        end
    end

    // capture saturated statistics as they are written back
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            case (i_cmd.ins.dst)
                R_MEAN:  r_st_mean <= sat_s(r_res, MEAN_W)[MEAN_W-1:0];
                R_VAR:   r_st_var  <= sat_u(r_res, VAR_W)[VAR_W-1:0];
                R_PSTD:  r_st_pstd <= sat_u(r_res, STD_W)[STD_W-1:0];
                R_SSTD:  r_st_sstd <= sat_u(r_res, STD_W)[STD_W-1:0];
                R_G1:    r_st_g1   <= sat_s(r_res, SKEW_W)[SKEW_W-1:0];
                R_BG1:   r_st_bg1  <= sat_s(r_res, SKEW_W)[SKEW_W-1:0];
                R_B1:    r_st_b1   <= sat_s(r_res, SKEW_W)[SKEW_W-1:0];
                R_G2:    r_st_g2   <= sat_s(r_res, KURT_W)[KURT_W-1:0];
                R_BG2:   r_st_bg2  <= sat_s(r_res, KURT_W)[KURT_W-1:0];
                R_B2:    r_st_b2   <= sat_s(r_res, KURT_W)[KURT_W-1:0];
                default: r_st_mean <= r_st_mean;
            endcase
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // output payload, all zero for a clear, small-count forms forced to zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            if (i_cmd.pub_clr) begin
                o_mean_value     <= '0;
                o_variance       <= '0;
                o_population_std <= '0;
                o_sample_std     <= '0;
                o_skew_g1        <= '0;
                o_skew_big_g1    <= '0;
                o_skew_b1        <= '0;
                o_kurt_g2        <= '0;
                o_kurt_big_g2    <= '0;
                o_kurt_b2        <= '0;
            end else begin
                o_mean_value     <= r_st_mean;
                o_variance       <= r_st_var;
                o_population_std <= r_st_pstd;
                o_sample_std     <= (r_count < CNT_BITS'(2)) ? '0 : r_st_sstd;
                o_skew_g1        <= r_st_g1;
                o_skew_big_g1    <= (r_count < CNT_BITS'(3)) ? '0 : r_st_bg1;
                o_skew_b1        <= r_st_b1;
                o_kurt_g2        <= r_st_g2;
                o_kurt_big_g2    <= (r_count < CNT_BITS'(4)) ? '0 : r_st_bg2;
                o_kurt_b2        <= r_st_b2;
            end
            o_minimum <= r_min;
            o_maximum <= r_max;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_COUNT))
        else $error("sample count beyond its limit");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_count == '0 && r_s1 == '0 && r_s4 == '0))
        else $error("clear left accumulated state");
    a_minmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min <= r_max)
        else $error("running minimum above maximum");
    a_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |=> r_ovalid)
        else $error("published result not presented");

endmodule

`default_nettype wire

/* dv/running_moment_statistics_test.sv */
// running_moment_statistics_test: self-checking bench for the running moment block
// depends on rms_pkg and running_moment_statistics; predicts every result with wide integers
`default_nettype none

module running_moment_statistics_test;
    import rms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FN_ADD   = 1'b0;
    localparam logic FN_CLEAR = 1'b1;
    localparam int   TOTAL_REQUESTS = 1950;
    localparam longint CYCLE_LIMIT  = 24_000_000;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic [MEAN_W-1:0]      mean_value;
        logic [VAR_W-1:0]       variance;
        logic [STD_W-1:0]       population_std;
        logic [STD_W-1:0]       sample_std;
        logic [SKEW_W-1:0]      skew_g1;
        logic [SKEW_W-1:0]      skew_big_g1;
        logic [SKEW_W-1:0]      skew_b1;
        logic [KURT_W-1:0]      kurt_g2;
        logic [KURT_W-1:0]      kurt_big_g2;
        logic [KURT_W-1:0]      kurt_b2;
        logic [SAMPLE_BITS-1:0] minimum;
        logic [SAMPLE_BITS-1:0] maximum;
    } moments_t;

    // predicts the statistics from exact power sums and checks results in order
    class moment_scoreboard;
        int unsigned count;
        longint      pow1, pow2, pow3, pow4;
        int          lo_seen, hi_seen;
        moments_t    pending[$];
        int          errors;
        int          matched;

        function void wipe();
            count = 0;
            pow1 = 0; pow2 = 0; pow3 = 0; pow4 = 0;
            lo_seen = 0; hi_seen = 0;
        endfunction

        // zero divisor gives zero, otherwise truncation toward zero
        function wide_t quot(wide_t a, wide_t b);
            if (b == 0) return 0;
            return a / b;
        endfunction

        function wide_t root(wide_t a);
            wide_t r;
            wide_t c;
            r = 0;
            for (int i = 127; i >= 0; i--) begin
                c = r | (wide_t'(1) << i);
                if ($unsigned(c * c) <= $unsigned(a)) r = c;
            end
            return r;
        endfunction

        function wide_t clamp_signed(wide_t v, int w);
            wide_t hi;
            wide_t lo;
            hi = (wide_t'(1) <<< (w - 1)) - 1;
            lo = -(wide_t'(1) <<< (w - 1));
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function wide_t clamp_unsigned(wide_t v, int w);
            wide_t mx;
            mx = (wide_t'(1) <<< w) - 1;
            if (v < 0) return 0;
            if (v > mx) return mx;
            return v;
        endfunction

        // accepted request: update the sums and queue the expected statistics
        function void note_request(logic func, logic signed [SAMPLE_BITS-1:0] smp);
            moments_t e;
            wide_t n, nm1, s1, s2, s3, s4, c2, c3, c4, g1, g2, t, u, num, three_f;
            int v;
            e = '0;
            if (func == FN_CLEAR) begin
                wipe();
                pending.push_back(e);
                return;
            end
            if (count < MAX_COUNT) begin
                v = smp;
                if (count == 0) begin
                    lo_seen = v;
                    hi_seen = v;
                end else begin
                    if (v > hi_seen) hi_seen = v;
                    if (v < lo_seen) lo_seen = v;
                end
                count++;
                pow1 += v;
                pow2 += longint'(v) * v;
                pow3 += longint'(v) * v * v;
                pow4 += longint'(v) * v * v * v;
            end
            n = count;
            nm1 = n - 1;
            s1 = pow1; s2 = pow2; s3 = pow3; s4 = pow4;
            three_f = wide_t'(3) <<< FRAC_BITS;
            c2 = n * s2 - s1 * s1;
            c3 = n * n * s3 - 3 * n * s1 * s2 + 2 * s1 * s1 * s1;
            c4 = n * n * n * s4 - 4 * n * n * s1 * s3 + 6 * n * s1 * s1 * s2
                 - 3 * s1 * s1 * s1 * s1;
            e.mean_value = clamp_signed(quot(s1 <<< FRAC_BITS, n), MEAN_W);
            e.variance = clamp_unsigned(quot(c2 <<< FRAC_BITS, n * n), VAR_W);
            e.population_std = clamp_unsigned(root(quot(c2 <<< (2 * FRAC_BITS), n * n)),
                                              STD_W);
            if (count >= 2)
                e.sample_std = clamp_unsigned(root(quot(c2 <<< (2 * FRAC_BITS), n * nm1)),
                                              STD_W);
            if (c2 == 0) begin
                g1 = 0;
                g2 = -three_f;
            end else begin
                g1 = quot(c3 <<< (2 * FRAC_BITS), c2 * root(c2 <<< (2 * FRAC_BITS)));
                g2 = quot(c4 <<< FRAC_BITS, c2 * c2) - three_f;
            end
            t = root(quot((nm1 * nm1 * nm1) <<< (2 * FRAC_BITS), n * n * n));
            e.skew_g1 = clamp_signed(g1, SKEW_W);
            e.skew_b1 = clamp_signed(quot(g1 * t, wide_t'(1) <<< FRAC_BITS), SKEW_W);
            if (count >= 3) begin
                u = root((n * nm1) <<< (2 * FRAC_BITS));
                e.skew_big_g1 = clamp_signed(quot(g1 * u, (n - 2) <<< FRAC_BITS), SKEW_W);
            end
            if (count >= 4) begin
                num = (n + 1) * g2 + (wide_t'(6) <<< FRAC_BITS);
                e.kurt_big_g2 = clamp_signed(quot(num * nm1, (n - 2) * (n - 3)), KURT_W);
            end
            e.kurt_g2 = clamp_signed(g2, KURT_W);
            e.kurt_b2 = clamp_signed(quot((g2 + three_f) * nm1 * nm1, n * n) - three_f,
                                     KURT_W);
            e.minimum = lo_seen[SAMPLE_BITS-1:0];
            e.maximum = hi_seen[SAMPLE_BITS-1:0];
            pending.push_back(e);
        endfunction

        function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t mismatch %s: expected %h actual %h", $realtime, name,
                         exp_v, act_v);
            end
        endfunction

        // accepted result: compare against the oldest expectation
        function void check_result(moments_t act);
            moments_t e;
            int before_err;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual %h", $realtime, act);
                return;
            end
            e = pending.pop_front();
            before_err = errors;
            check_field("mean_value", e.mean_value, act.mean_value);
            check_field("variance", e.variance, act.variance);
            check_field("population_std", e.population_std, act.population_std);
            check_field("sample_std", e.sample_std, act.sample_std);
            check_field("skew_g1", e.skew_g1, act.skew_g1);
            check_field("skew_big_g1", e.skew_big_g1, act.skew_big_g1);
            check_field("skew_b1", e.skew_b1, act.skew_b1);
            check_field("kurt_g2", e.kurt_g2, act.kurt_g2);
            check_field("kurt_big_g2", e.kurt_big_g2, act.kurt_big_g2);
            check_field("kurt_b2", e.kurt_b2, act.kurt_b2);
            check_field("minimum", e.minimum, act.minimum);
            check_field("maximum", e.maximum, act.maximum);
            if (errors == before_err) matched++;
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          func = FN_ADD;
    logic signed [SAMPLE_BITS-1:0] smp = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    moments_t                      act;

    moment_scoreboard sb = new();
    longint cycles = 0;
    int     results_seen = 0;
    int     samples_sent = 0;
    int     clears_sent = 0;
    int     requests_sent = 0;
    int     hold_left = 0;
    bit     hold_done = 1'b0;

    running_moment_statistics u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_func           (func),
        .i_sample         (smp),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_mean_value     (act.mean_value),
        .o_variance       (act.variance),
        .o_population_std (act.population_std),
        .o_sample_std     (act.sample_std),
        .o_skew_g1        (act.skew_g1),
        .o_skew_big_g1    (act.skew_big_g1),
        .o_skew_b1        (act.skew_b1),
        .o_kurt_g2        (act.kurt_g2),
        .o_kurt_big_g2    (act.kurt_big_g2),
        .o_kurt_b2        (act.kurt_b2),
        .o_minimum        (act.minimum),
        .o_maximum        (act.maximum)
    );

    // clock
    initial begin
        forever #6 clk = ~clk;
    end

    // cycle count and timeout
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL running_moment_statistics");
            $finish;
        end
    end

    // result side: random stall, one long hold-off, a calm stretch
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (!hold_done && results_seen >= 300) begin
            hold_done <= 1'b1;
            hold_left <= 12000;
            out_stall <= 1'b1;
        end else if (results_seen >= 900 && results_seen < 1100) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < 12);
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(act);
            results_seen <= results_seen + 1;
        end
    end

    // offer one request and hold it until taken
    task automatic send(input logic f, input logic signed [SAMPLE_BITS-1:0] s);
        in_valid <= 1'b1;
        func     <= f;
        smp      <= s;
        do @(posedge clk); while (in_stall);
        sb.note_request(f, s);
        requests_sent++;
        if (f == FN_CLEAR) clears_sent++;
        else samples_sent++;
    endtask

    // random pause on the request side, none in the calm stretch
    task automatic maybe_idle();
        if (!(requests_sent >= 600 && requests_sent < 800) && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // draw a sample according to the current shape of the data
    function automatic logic signed [SAMPLE_BITS-1:0] draw(int shape,
                                                          logic signed [SAMPLE_BITS-1:0] k);
        case (shape)
            0: return $urandom;
            1: return k + $signed(SAMPLE_BITS'($urandom_range(0, 15))) - 8;
            2: return k;
            3: return ($urandom_range(99) < 10) ? SAMPLE_BITS'($urandom) :
                      SAMPLE_BITS'($urandom_range(0, 3));
            default: return ($urandom_range(1)) ? 12'sh7ff : 12'sh800;
        endcase
    endfunction

    initial begin
        int shape;
        logic signed [SAMPLE_BITS-1:0] center;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, equal samples, small counts, clears
        send(FN_ADD, 12'sh800);
        send(FN_ADD, 12'sh800);
        send(FN_ADD, 12'sh800);
        send(FN_ADD, 12'sh7ff);
        send(FN_ADD, 12'sh7ff);
        send(FN_ADD, 12'sh000);
        send(FN_CLEAR, 12'sh5a5);
        send(FN_CLEAR, 12'sh000);
        send(FN_ADD, 12'sh7ff);
        send(FN_ADD, 12'sh800);
        send(FN_ADD, 12'sh7ff);
        send(FN_ADD, 12'sh800);
        send(FN_CLEAR, 12'shfff);
        send(FN_ADD, 12'sh001);
        send(FN_ADD, 12'sh001);
        send(FN_ADD, 12'sh001);
        send(FN_ADD, 12'sh001);
        send(FN_ADD, 12'sh001);
        send(FN_ADD, 12'sh7ff);
        send(FN_CLEAR, 12'sh000);
        send(FN_ADD, 12'shfff);
        send(FN_ADD, 12'sh000);
        send(FN_ADD, 12'sh000);
        send(FN_ADD, 12'sh000);

        // random runs of samples split by clears, each run with its own shape
        shape  = 0;
        center = '0;
        while (requests_sent < TOTAL_REQUESTS) begin
            maybe_idle();
            if ($urandom_range(99) < 3) begin
                send(FN_CLEAR, SAMPLE_BITS'($urandom));
                shape  = $urandom_range(0, 4);
                center = $urandom;
            end else begin
                send(FN_ADD, draw(shape, center));
            end
        end
        in_valid <= 1'b0;

        // drain, then let the block settle
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4000) @(posedge clk);
        $display("covered %0d samples and %0d clears, %0d results matched",
                 samples_sent, clears_sent, sb.matched);
        $display("runs used full-range, narrow, constant, skewed and extreme data");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS running_moment_statistics");
        end else begin
            $display("FAIL running_moment_statistics");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* running_moment_statistics.f */
src/rms_pkg.sv
src/rms_ctrl.sv
src/rms_dp.sv
src/running_moment_statistics.sv
dv/running_moment_statistics_test.sv
